>>> hw/rtl/indexed_ordered_list_defines.svh
// ----------------------------------------------------------------------------
// Indexed ordered list assertion macros
// Shared concurrent assertion forms, sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef INDEXED_ORDERED_LIST_DEFINES_SVH
`define INDEXED_ORDERED_LIST_DEFINES_SVH

// Same-cycle implication.
`define IOL_ASSERT_IMP(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("indexed ordered list assertion failed");

// Next-cycle implication.
`define IOL_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("indexed ordered list assertion failed");

`endif

>>> hw/rtl/iol_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed ordered list package
// Field widths, operation and status codes, and controller interface types.
// ----------------------------------------------------------------------------
package iol_pkg;

    localparam int IOL_DEPTH      = 16;
    localparam int IOL_DATA_WIDTH = 32;

    localparam int FUNC_W = 3;
    localparam int POS_W  = 4;
    localparam int VAL_W  = 32;
    localparam int ST_W   = 2;
    localparam int LEN_W  = 5;
    localparam int ACT_W  = 2;

    localparam logic [FUNC_W-1:0] FN_PUSH   = 3'd0;
    localparam logic [FUNC_W-1:0] FN_APPEND = 3'd1;
    localparam logic [FUNC_W-1:0] FN_INSERT = 3'd2;
    localparam logic [FUNC_W-1:0] FN_READ   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_DELETE = 3'd4;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    localparam logic [ACT_W-1:0] ACT_NONE   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ   = 2'd2;
    localparam logic [ACT_W-1:0] ACT_DELETE = 2'd3;

    typedef struct packed {
        logic load;
        logic idx_init;
        logic rd;
        logic wr_shift;
        logic finish;
    } iol_cmd_t;

    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic             shift_more;
        logic             out_free;
    } iol_stat_t;

endpackage

>>> hw/rtl/iol_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed ordered list controller
// Sequences request capture, entry moves and result hand-off.
// ----------------------------------------------------------------------------
module iol_ctrl
    import iol_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  iol_stat_t stat,
    output iol_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_START  = 3'd1;
    localparam logic [2:0] S_CHECK  = 3'd2;
    localparam logic [2:0] S_MOVE   = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                cmd.idx_init = 1'b1;
                if (stat.act == ACT_INSERT || stat.act == ACT_DELETE)
                begin
                    state_next = S_CHECK;
                end
                else
                begin
                    cmd.rd     = (stat.act == ACT_READ);
                    state_next = S_FINISH;
                end
            end
            S_CHECK:
            begin
                if (stat.shift_more)
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_MOVE;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_MOVE:
            begin
                cmd.wr_shift = 1'b1;
                state_next   = S_CHECK;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hw/rtl/iol_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed ordered list datapath
// Entry memory, length counter, request checks and the result register.
// ----------------------------------------------------------------------------
`include "indexed_ordered_list_defines.svh"

module iol_datapath
    import iol_pkg::*;
#(
    parameter int DEPTH      = IOL_DEPTH,
    parameter int DATA_WIDTH = IOL_DATA_WIDTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  iol_cmd_t          cmd,
    output iol_stat_t         stat,
    input  logic [FUNC_W-1:0] func,
    input  logic [POS_W-1:0]  position,
    input  logic [VAL_W-1:0]  item_value,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [VAL_W-1:0]  read_value,
    output logic [ST_W-1:0]   status,
    output logic [LEN_W-1:0]  list_length
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    logic [FUNC_W-1:0]     func_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [DATA_WIDTH-1:0] val_reg;
    logic [DATA_WIDTH-1:0] rdata_reg;
    logic [AW-1:0]         idx_reg;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic                  out_valid_reg;
    logic [VAL_W-1:0]      out_data_reg;
    logic [ST_W-1:0]       out_status_reg;
    logic [LEN_W-1:0]      out_len_reg;

    logic [PW-1:0]    pos_x;
    logic [PW-1:0]    cnt_x;
    logic [PW-1:0]    ins_pos_x;
    logic             full;
    logic [ACT_W-1:0] act;
    logic [ST_W-1:0]  st;
    logic [AW-1:0]    rd_addr;

    assign pos_x = PW'(pos_reg);
    assign cnt_x = PW'(count_reg);
    assign full  = (cnt_x == PW'(DEPTH));

    always_comb
    begin
        act       = ACT_NONE;
        st        = ST_OK;
        ins_pos_x = pos_x;
        case (func_reg)
            FN_PUSH:
            begin
                ins_pos_x = '0;
                if (full)
                    st = ST_FULL;
                else
                    act = ACT_INSERT;
            end
            FN_APPEND:
            begin
                ins_pos_x = cnt_x;
                if (full)
                    st = ST_FULL;
                else
                    act = ACT_INSERT;
            end
            FN_INSERT:
            begin
                if (full)
                    st = ST_FULL;
                else if (count_reg == '0 || pos_x > cnt_x)
                    st = ST_RANGE;
                else
                    act = ACT_INSERT;
            end
            FN_READ:
            begin
                if (pos_x < cnt_x)
                    act = ACT_READ;
                else
                    st = ST_RANGE;
            end
            FN_DELETE:
            begin
                if (pos_x < cnt_x)
                    act = ACT_DELETE;
                else
                    st = ST_RANGE;
            end
            default:
            begin
                st = ST_RANGE;
            end
        endcase
    end

    always_comb
    begin
        case (act)
            ACT_INSERT: rd_addr = idx_reg - AW'(1);
            ACT_DELETE: rd_addr = idx_reg + AW'(1);
            default:    rd_addr = pos_x[AW-1:0];
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.finish && act == ACT_INSERT)
            count_next = count_reg + CW'(1);
        else if (cmd.finish && act == ACT_DELETE)
            count_next = count_reg - CW'(1);
    end

    assign stat.act        = act;
    assign stat.shift_more = (act == ACT_INSERT) ? (PW'(idx_reg) > ins_pos_x)
                                                 : ((PW'(idx_reg) + PW'(1)) < cnt_x);
    assign stat.out_free   = !out_valid_reg || !out_stall;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func;
            pos_reg  <= position;
            val_reg  <= DATA_WIDTH'(item_value);
        end
        if (cmd.idx_init)
        begin
            if (act == ACT_INSERT)
                idx_reg <= ins_pos_x == cnt_x ? cnt_x[AW-1:0] : count_reg[AW-1:0];
            else
                idx_reg <= pos_x[AW-1:0];
        end
        else if (cmd.wr_shift)
        begin
            if (act == ACT_INSERT)
                idx_reg <= idx_reg - AW'(1);
            else
                idx_reg <= idx_reg + AW'(1);
        end
        if (cmd.rd)
            rdata_reg <= mem[rd_addr];
        if (cmd.wr_shift)
            mem[idx_reg] <= rdata_reg;
        else if (cmd.finish && act == ACT_INSERT)
            mem[idx_reg] <= val_reg;
        if (cmd.finish)
        begin
            out_data_reg   <= (act == ACT_READ) ? VAL_W'(rdata_reg) : '0;
            out_status_reg <= st;
            out_len_reg    <= LEN_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.finish)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_value  = out_data_reg;
    assign status      = out_status_reg;
    assign list_length = out_len_reg;

    `IOL_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CW'(DEPTH))
    `IOL_ASSERT_NEXT(a_insert_grows, cmd.finish && act == ACT_INSERT,
        count_reg == $past(count_reg) + CW'(1))
    `IOL_ASSERT_NEXT(a_result_source, !out_valid_reg && !cmd.finish, !out_valid_reg)
    `IOL_ASSERT_IMP(a_finish_slot, cmd.finish, !out_valid_reg || !out_stall)

endmodule

>>> hw/rtl/indexed_ordered_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed ordered list
// Bounded list of data words with push, append, insert, read and delete
// by position; each request returns one result transaction.
// ----------------------------------------------------------------------------
// Channel   Handshake            Payload
// input     in_valid, in_stall   func, position, item_value
// output    out_valid, out_stall read_value, status, list_length
//
// A read or a rejected request passes through the start and finish states
// before the next acceptance; insert and delete add a check state and a
// check-and-move pass per entry moved, since each move is one read and one
// write of the single-port entry memory.
// Reset clears the length; entry memory is not cleared.
// A stalled result holds the finished request until the result slot frees.
// ----------------------------------------------------------------------------
module indexed_ordered_list
    import iol_pkg::*;
#(
    parameter int DEPTH      = IOL_DEPTH,
    parameter int DATA_WIDTH = IOL_DATA_WIDTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [FUNC_W-1:0] func,
    input  logic [POS_W-1:0]  position,
    input  logic [VAL_W-1:0]  item_value,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [VAL_W-1:0]  read_value,
    output logic [ST_W-1:0]   status,
    output logic [LEN_W-1:0]  list_length
);

    iol_cmd_t  cmd;
    iol_stat_t stat;

    iol_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    iol_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .func        (func),
        .position    (position),
        .item_value  (item_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_value  (read_value),
        .status      (status),
        .list_length (list_length)
    );

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed ordered list testbench
// Sends push, append, insert, read and delete requests, including rejected
// and unknown ones, and checks every result transaction against a list kept
// in the testbench. The sender idles between bursts and the receiver stalls in
// random windows, with one long hold-off that backs up the input channel.
// ----------------------------------------------------------------------------
module testbench;
    import iol_pkg::*;

    localparam int RUN_LIMIT   = 600000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 60;

    typedef struct packed {
        logic [VAL_W-1:0] read_value;
        logic [ST_W-1:0]  status;
        logic [LEN_W-1:0] list_length;
    } list_reply_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [FUNC_W-1:0] func = FN_PUSH;
    logic [POS_W-1:0]  position = '0;
    logic [VAL_W-1:0]  item_value = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [VAL_W-1:0]  read_value;
    logic [ST_W-1:0]   status;
    logic [LEN_W-1:0]  list_length;

    logic [VAL_W-1:0]  list_words [IOL_DEPTH];
    int                list_count = 0;
    list_reply_t       pending_replies [$];

    int                error_count = 0;
    int                cycle_count = 0;
    bit                sender_gaps = 1'b1;
    int                burst_left = 0;
    int                stall_ceiling = 0;
    int                stall_pct = 0;
    int                window_left = 0;
    int                hold_serial = 0;
    int                hold_seen = 0;
    int                hold_left = 0;

    indexed_ordered_list dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .position    (position),
        .item_value  (item_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_value  (read_value),
        .status      (status),
        .list_length (list_length)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // The receiver stalls in windows of random length and density, and
    // holds off completely for a long stretch when a test asks for it.
    always @(posedge clk)
    begin
        if (hold_seen != hold_serial)
        begin
            hold_seen <= hold_serial;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            if (window_left == 0)
            begin
                window_left <= $urandom_range(16, 96);
                stall_pct <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, stall_ceiling);
            end
            else
            begin
                window_left <= window_left - 1;
            end
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Applies one request to the testbench copy of the list and returns the
    // result transaction that the block must produce for it.
    function automatic list_reply_t apply_list_request(input logic [FUNC_W-1:0] f,
                                                       input logic [POS_W-1:0] p,
                                                       input logic [VAL_W-1:0] v);
        list_reply_t reply;
        int          slot;
        reply.read_value = '0;
        reply.status = ST_OK;
        case (f)
            FN_PUSH, FN_APPEND, FN_INSERT:
            begin
                if (list_count >= IOL_DEPTH)
                begin
                    reply.status = ST_FULL;
                end
                else if (f == FN_INSERT && (list_count == 0 || int'(p) > list_count))
                begin
                    reply.status = ST_RANGE;
                end
                else
                begin
                    slot = (f == FN_PUSH) ? 0 : (f == FN_APPEND) ? list_count : int'(p);
                    for (int i = list_count; i > slot; i--)
                        list_words[i] = list_words[i - 1];
                    list_words[slot] = v;
                    list_count++;
                end
            end
            FN_READ:
            begin
                if (int'(p) >= list_count)
                    reply.status = ST_RANGE;
                else
                    reply.read_value = list_words[p];
            end
            FN_DELETE:
            begin
                if (int'(p) >= list_count)
                begin
                    reply.status = ST_RANGE;
                end
                else
                begin
                    for (int i = int'(p); i < list_count - 1; i++)
                        list_words[i] = list_words[i + 1];
                    list_count--;
                end
            end
            default:
            begin
                reply.status = ST_RANGE;
            end
        endcase
        reply.list_length = list_count[LEN_W-1:0];
        return reply;
    endfunction

    always @(posedge clk)
    begin : check_reply
        list_reply_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_replies.size() == 0)
            begin
                $display("%0t: unexpected result transaction, expected none, actual %h/%0d/%0d",
                         $time, read_value, status, list_length);
                error_count++;
            end
            else
            begin
                want = pending_replies.pop_front();
                if (read_value !== want.read_value)
                begin
                    $display("%0t: read_value expected %h actual %h",
                             $time, want.read_value, read_value);
                    error_count++;
                end
                if (status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, status);
                    error_count++;
                end
                if (list_length !== want.list_length)
                begin
                    $display("%0t: list_length expected %0d actual %0d",
                             $time, want.list_length, list_length);
                    error_count++;
                end
            end
        end
    end

    task automatic send_request(input logic [FUNC_W-1:0] f, input logic [POS_W-1:0] p,
                                input logic [VAL_W-1:0] v);
        int gap;
        if (sender_gaps && burst_left == 0)
        begin
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
        in_valid <= 1'b1;
        func <= f;
        position <= p;
        item_value <= v;
        do
            @(posedge clk);
        while (in_stall);
        pending_replies.push_back(apply_list_request(f, p, v));
        if (burst_left > 0)
            burst_left--;
    endtask

    function automatic logic [VAL_W-1:0] random_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_empty_list();
        send_request(FN_READ, 4'd0, '1);
        send_request(FN_DELETE, 4'd0, '0);
        send_request(FN_INSERT, 4'd0, 32'h1234_5678);
        for (int f = int'(FN_DELETE) + 1; f < (1 << FUNC_W); f++)
            send_request(f[FUNC_W-1:0], '1, '1);
    endtask

    task automatic test_basic_edits();
        send_request(FN_PUSH, 4'd0, 32'hFFFF_FFFF);
        send_request(FN_APPEND, 4'd15, 32'h0000_0000);
        send_request(FN_INSERT, 4'd2, 32'hA5A5_A5A5);
        send_request(FN_INSERT, 4'd1, 32'h5A5A_5A5A);
        send_request(FN_INSERT, 4'd15, 32'hDEAD_BEEF);
        send_request(FN_READ, 4'd3, '0);
        send_request(FN_READ, 4'd15, '0);
        send_request(FN_DELETE, 4'd0, '0);
        send_request(FN_READ, 4'd0, '0);
        send_request(FN_DELETE, 4'd2, '0);
        send_request(FN_DELETE, 4'd3, '0);
        send_request(FN_READ, 4'd1, '0);
    endtask

    task automatic test_full_list();
        while (list_count < IOL_DEPTH)
            send_request(FN_APPEND, POS_W'($urandom), random_word());
        send_request(FN_PUSH, 4'd0, '1);
        send_request(FN_APPEND, 4'd0, '1);
        send_request(FN_INSERT, 4'd15, '1);
        send_request(FN_READ, 4'd15, '0);
        send_request(FN_DELETE, 4'd15, '0);
        send_request(FN_INSERT, 4'd15, 32'hCAFE_F00D);
        send_request(FN_READ, 4'd15, '0);
        send_request(FN_DELETE, 4'd0, '0);
        send_request(FN_READ, 4'd0, '0);
    endtask

    task automatic test_backpressure();
        sender_gaps = 1'b0;
        hold_serial++;
        for (int k = 0; k < 16; k++)
            send_request(FUNC_W'($urandom_range(int'(FN_PUSH), int'(FN_DELETE))),
                         POS_W'($urandom_range(0, 3)), random_word());
        sender_gaps = 1'b1;
    endtask

    // Mostly well-formed requests that steer the length toward a moving
    // target, mixed with requests whose fields are fully random.
    task automatic test_random_traffic(input int count, input bit gaps, input int ceiling);
        int               target_len;
        int               choice;
        logic [VAL_W-1:0] word;
        sender_gaps = gaps;
        stall_ceiling = ceiling;
        target_len = 0;
        for (int k = 0; k < count; k++)
        begin
            if (k % 40 == 0)
            begin
                if ($urandom_range(0, 2) == 0)
                    target_len = $urandom_range(0, 1) ? IOL_DEPTH : 0;
                else
                    target_len = $urandom_range(0, IOL_DEPTH);
            end
            word = random_word();
            choice = $urandom_range(0, 99);
            if (choice < 12)
            begin
                send_request(FUNC_W'($urandom_range(0, (1 << FUNC_W) - 1)),
                             POS_W'($urandom_range(0, IOL_DEPTH - 1)), word);
            end
            else if (list_count < target_len || (list_count == target_len && choice < 30))
            begin
                case ($urandom_range(0, 2))
                    0: send_request(FN_PUSH, POS_W'($urandom), word);
                    1: send_request(FN_APPEND, POS_W'($urandom), word);
                    default:
                        send_request(FN_INSERT, POS_W'($urandom_range(0, list_count)), word);
                endcase
            end
            else if (list_count > target_len || (list_count != 0 && choice < 45))
            begin
                send_request(FN_DELETE, POS_W'($urandom_range(0, list_count - 1)), word);
            end
            else if (list_count != 0)
            begin
                send_request(FN_READ, POS_W'($urandom_range(0, list_count - 1)), word);
            end
            else
            begin
                send_request(FN_READ, POS_W'($urandom_range(0, IOL_DEPTH - 1)), word);
            end
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        stall_ceiling = 50;
        test_empty_list();
        test_basic_edits();
        test_full_list();
        test_backpressure();
        test_random_traffic(400, 1'b1, 60);
        test_random_traffic(400, 1'b0, 0);
        test_random_traffic(400, 1'b1, 90);
        test_random_traffic(400, 1'b0, 40);

        in_valid <= 1'b0;
        stall_ceiling = 0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (error_count == 0 && pending_replies.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/iol_pkg.sv
hw/rtl/iol_ctrl.sv
hw/rtl/iol_datapath.sv
hw/rtl/indexed_ordered_list.sv
tb/sv/testbench.sv
